// File: hw/rtl/rlgd_pkg.sv
// Shared types, codes and constant tables for the RGB LED effect and gamma driver.
// Depends on nothing; every other file of the block imports it.
package rlgd_pkg;

   localparam int LEVEL_W  = 13;
   localparam int NOW_W    = 32;
   localparam int MS_W     = 16;
   localparam int FRAME_W  = 6;
   localparam int CODE_W   = 3;
   localparam int PROD_W   = 2 * LEVEL_W;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 13'h1fff;
   localparam logic [13:0]        PULSE_FULL = 14'(FULL_LEVEL);

   // Operation codes of an input beat
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FLASH = 1'b1;

   // Configuration register indexes
   localparam logic CSR_BASE_EFFECT = 1'b0;
   localparam logic CSR_BASE_COLOR  = 1'b1;

   // Effect codes; the upper three alias the lower ones (code modulo five)
   localparam logic [CODE_W-1:0] EFF_OFF       = 3'd0;
   localparam logic [CODE_W-1:0] EFF_SOLID     = 3'd1;
   localparam logic [CODE_W-1:0] EFF_BLINK     = 3'd2;
   localparam logic [CODE_W-1:0] EFF_PULSE     = 3'd3;
   localparam logic [CODE_W-1:0] EFF_FLASH     = 3'd4;
   localparam logic [CODE_W-1:0] EFF_OFF_ALT   = 3'd5;
   localparam logic [CODE_W-1:0] EFF_SOLID_ALT = 3'd6;
   localparam logic [CODE_W-1:0] EFF_BLINK_ALT = 3'd7;

   // Colour indexes
   localparam logic [CODE_W-1:0] COL_BLUE      = 3'd0;
   localparam logic [CODE_W-1:0] COL_GREEN     = 3'd1;
   localparam logic [CODE_W-1:0] COL_CYAN      = 3'd2;
   localparam logic [CODE_W-1:0] COL_RED       = 3'd3;
   localparam logic [CODE_W-1:0] COL_MAGENTA   = 3'd4;
   localparam logic [CODE_W-1:0] COL_ORANGE    = 3'd5;
   localparam logic [CODE_W-1:0] COL_WHITE     = 3'd6;
   localparam logic [CODE_W-1:0] COL_BLUE_ALT  = 3'd7;

   // Channel positions within an rgb_type
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef logic [2:0][LEVEL_W-1:0] rgb_type;

   typedef struct packed {
      logic                 operation;
      logic [NOW_W-1:0]     now_ticks;
      logic [MS_W-1:0]      flash_ms;
      logic [CODE_W-1:0]    flash_effect_sel;
      logic [CODE_W-1:0]    flash_color_sel;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_duty;
      logic [LEVEL_W-1:0] green_duty;
      logic [LEVEL_W-1:0] blue_duty;
      logic               flash_shown;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SHADE,
      ST_OUT,
      ST_DIV,
      ST_ARM
   } state_type;

   typedef enum logic [1:0] {
      PH_SCALE,
      PH_SQUARE,
      PH_CUBE
   } phase_type;

   function automatic logic [LEVEL_W-1:0] effect_level(input logic [CODE_W-1:0] effect,
                                                      input logic [FRAME_W-1:0] frame);
      logic [13:0]        x;
      logic [13:0]        d;
      logic [LEVEL_W-1:0] lvl;
      x = {frame, 8'h00};
      d = (x >= PULSE_FULL) ? (x - PULSE_FULL) : (PULSE_FULL - x);
      unique case (effect) inside
         EFF_SOLID, EFF_SOLID_ALT: lvl = FULL_LEVEL;
         EFF_BLINK, EFF_BLINK_ALT: lvl = frame[4] ? FULL_LEVEL : '0;
         EFF_PULSE:                lvl = LEVEL_W'(PULSE_FULL - d);
         EFF_FLASH:                lvl = frame[2] ? FULL_LEVEL : '0;
         EFF_OFF, EFF_OFF_ALT:     lvl = '0;
         default:                  lvl = '0;
      endcase
      return lvl;
   endfunction

   function automatic rgb_type color_rgb(input logic [CODE_W-1:0] idx);
      rgb_type c;
      unique case (idx) inside
         COL_BLUE, COL_BLUE_ALT: c = {13'd8191, 13'd0,    13'd0};
         COL_GREEN:              c = {13'd0,    13'd8191, 13'd0};
         COL_CYAN:               c = {13'd8191, 13'd8191, 13'd0};
         COL_RED:                c = {13'd0,    13'd0,    13'd8191};
         COL_MAGENTA:            c = {13'd8191, 13'd0,    13'd8191};
         COL_ORANGE:             c = {13'd0,    13'd5000, 13'd8191};
         COL_WHITE:              c = {13'd6700, 13'd7200, 13'd8191};
         default:                c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/rgb_led_effect_gamma_driver_top.sv
// Top level of the RGB LED effect and gamma driver: sequencer, state and beat registers.
// Depends on rlgd_pkg and rlgd_shade.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   rlgd_pkg::req_type
//   rsp      out        rsp_valid/stall   rlgd_pkg::rsp_type
//   csr      in         csr_valid/ready   csr_index (1 bit), csr_data (3 bits)
//
// A tick beat's result is loaded after acceptance in order: picking the effect, nine
// products through the shade unit's shared multiplier, a write-back, registering done
// and a load. The next beat can be taken once the sequencer is back in idle. A
// start-flash beat holds req_stall in ST_DIV, flash_ms times the constant reciprocal
// of MS_PER_TICK, then in ST_ARM, the end-time add.
// req_stall is high for the whole of a beat's work; csr_ready only while idle.
// A result held by rsp_stall does not block acceptance of the next beat.
// Reset is synchronous and restores the base effect (solid) and colour (red).
module rgb_led_effect_gamma_driver_top #(
   parameter int MS_PER_TICK = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlgd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlgd_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [2:0]        csr_data
);
   import rlgd_pkg::*;

   // floor(ms / MS_PER_TICK) as (ms * RECIP) >> RECIP_SH, exact for every 16-bit ms
   localparam int RECIP_SH = MS_W + $clog2(MS_PER_TICK);
   localparam int RECIP_W  = MS_W + 1;
   localparam int QPROD_W  = 2 * MS_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SH) +
      64'(MS_PER_TICK) - 64'd1) / 64'(MS_PER_TICK));

   state_type            state_ff;
   state_type            state_in;
   req_type              req_ff;
   logic [CODE_W-1:0]    base_effect_ff;
   logic [CODE_W-1:0]    base_color_ff;
   logic [FRAME_W-1:0]   frame_ff;
   logic                 pend_ff;
   logic [CODE_W-1:0]    fl_eff_ff;
   logic [CODE_W-1:0]    fl_col_ff;
   logic [NOW_W-1:0]     fl_end_ff;
   logic                 shown_ff;
   logic [MS_W-1:0]      q_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 req_acc;
   logic                 csr_acc;
   logic                 out_free;
   logic                 use_flash;
   logic [CODE_W-1:0]    sel_eff;
   logic [CODE_W-1:0]    sel_col;
   logic [LEVEL_W-1:0]   sel_level;
   rgb_type              sel_rgb;
   logic                 shade_start;
   logic                 shade_done;
   rgb_type              shade_duty;
   logic [QPROD_W-1:0]   quot_prod;

   assign req_acc  = req_valid && !req_stall;
   assign csr_acc  = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Effect selection; flash expiry is a plain unsigned compare
   assign use_flash = pend_ff && (req_ff.now_ticks < fl_end_ff);
   assign sel_eff   = use_flash ? fl_eff_ff : base_effect_ff;
   assign sel_col   = use_flash ? fl_col_ff : base_color_ff;
   assign sel_level = effect_level(sel_eff, frame_ff);
   assign sel_rgb   = color_rgb(sel_col);

   assign quot_prod = QPROD_W'(req_ff.flash_ms) * QPROD_W'(RECIP);

   rlgd_shade u_shade (
      .clock (clock),
      .reset (reset),
      .start (shade_start),
      .level (sel_level),
      .rgb   (sel_rgb),
      .done  (shade_done),
      .duty  (shade_duty)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_payload.operation == OP_TICK) ? ST_EVAL : ST_DIV;
            end
         end
         ST_EVAL:  state_in = ST_SHADE;
         ST_SHADE: begin
            if (shade_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:   state_in = ST_ARM;
         ST_ARM:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      csr_ready   = (state_ff == ST_IDLE);
      shade_start = (state_ff == ST_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         base_effect_ff <= EFF_SOLID;
         base_color_ff  <= COL_RED;
         frame_ff       <= '0;
         pend_ff        <= 1'b0;
         fl_eff_ff      <= EFF_OFF;
         fl_col_ff      <= COL_BLUE;
         fl_end_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_acc) begin
            unique case (csr_index)
               CSR_BASE_EFFECT: base_effect_ff <= csr_data;
               CSR_BASE_COLOR:  base_color_ff  <= csr_data;
               default:         base_effect_ff <= base_effect_ff;
            endcase
            frame_ff <= '0;
         end
         if (state_ff == ST_EVAL) begin
            if (!use_flash) begin
               pend_ff <= 1'b0;
            end
            frame_ff <= frame_ff + FRAME_W'(1);
         end
         if (state_ff == ST_ARM) begin
            frame_ff  <= '0;
            pend_ff   <= 1'b1;
            fl_eff_ff <= req_ff.flash_effect_sel;
            fl_col_ff <= req_ff.flash_color_sel;
            fl_end_ff <= req_ff.now_ticks + NOW_W'(q_ff);
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         req_ff <= req_payload;
      end
      if (state_ff == ST_DIV) begin
         // scale flash_ms down to ticks
         q_ff <= MS_W'(quot_prod >> RECIP_SH);
      end
      if (state_ff == ST_EVAL) begin
         shown_ff <= use_flash;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_ff.red_duty    <= shade_duty[CH_RED];
         rsp_ff.green_duty  <= shade_duty[CH_GREEN];
         rsp_ff.blue_duty   <= shade_duty[CH_BLUE];
         rsp_ff.flash_shown <= shown_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/rlgd_shade.sv
// Shade unit: scales an rgb colour by a level, cubes each channel and inverts it.
// Nine products in turn through one registered 13x13 multiplier. Uses rlgd_pkg.
module rlgd_shade (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [12:0]       level,
   input  rlgd_pkg::rgb_type rgb,
   output logic              done,
   output rlgd_pkg::rgb_type duty
);
   import rlgd_pkg::*;

   logic                busy_ff;
   logic                busy_in;
   phase_type           ph_ff;
   phase_type           ph_in;
   logic [1:0]          ch_ff;
   logic [1:0]          ch_in;
   logic [LEVEL_W-1:0]  lvl_ff;
   rgb_type             rgb_ff;
   logic [PROD_W-1:0]   p_ff;
   logic [PROD_W-1:0]   p_in;
   logic [LEVEL_W-1:0]  s_ff;
   logic                wb_ff;
   logic [1:0]          wb_ch_ff;
   logic                done_ff;
   rgb_type             duty_ff;
   logic [LEVEL_W-1:0]  op_a;
   logic [LEVEL_W-1:0]  op_b;
   logic [LEVEL_W-1:0]  comp;
   logic [LEVEL_W-1:0]  p_hi;

   assign p_hi = p_ff[PROD_W-1:LEVEL_W];

   always_comb begin
      case (ch_ff)
         CH_RED:   comp = rgb_ff[CH_RED];
         CH_GREEN: comp = rgb_ff[CH_GREEN];
         CH_BLUE:  comp = rgb_ff[CH_BLUE];
         default:  comp = '0;
      endcase
   end

   // Next phase and channel
   always_comb begin
      ph_in   = ph_ff;
      ch_in   = ch_ff;
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         ph_in   = PH_SCALE;
         ch_in   = CH_RED;
      end else if (busy_ff) begin
         unique case (ph_ff)
            PH_SCALE:  ph_in = PH_SQUARE;
            PH_SQUARE: ph_in = PH_CUBE;
            PH_CUBE: begin
               ph_in = PH_SCALE;
               if (ch_ff == CH_BLUE) begin
                  busy_in = 1'b0;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
            default:   ph_in = PH_SCALE;
         endcase
      end
   end

   // Multiplier operands per phase
   always_comb begin
      unique case (ph_ff)
         PH_SCALE: begin
            op_a = comp;
            op_b = lvl_ff;
         end
         PH_SQUARE: begin
            op_a = p_hi;
            op_b = p_hi;
         end
         PH_CUBE: begin
            op_a = p_hi;
            op_b = s_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      p_in = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ph_ff   <= PH_SCALE;
         ch_ff   <= CH_RED;
         wb_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ph_ff   <= ph_in;
         ch_ff   <= ch_in;
         wb_ff   <= busy_ff && (ph_ff == PH_CUBE);
         done_ff <= wb_ff && (wb_ch_ff == CH_BLUE);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         lvl_ff <= level;
         rgb_ff <= rgb;
      end
      p_ff     <= p_in;
      wb_ch_ff <= ch_ff;
      // hold the scaled value for the cube step
      if (ph_ff == PH_SQUARE) begin
         s_ff <= p_hi;
      end
      if (wb_ff) begin
         duty_ff[wb_ch_ff] <= FULL_LEVEL - p_hi;
      end
   end

   assign done = done_ff;
   assign duty = duty_ff;

endmodule

// File: hw/rtl/rlgd_checker.sv
// Port-level checks for the RGB LED effect and gamma driver, bound to its top level.
// Depends on rlgd_pkg and rgb_led_effect_gamma_driver_top.
module rlgd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rlgd_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rlgd_pkg::rsp_type rsp_payload,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              csr_index,
   input logic [2:0]        csr_data
);
   import rlgd_pkg::*;

   // An accepted beat keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req_stall low right after an accepted beat");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result beat changed or dropped");

   // A new result only appears after the block has been working
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat rose while the block was idle");

   // Register writes land only while the block is idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !req_stall)
      else $error("register write taken while a beat is at work");

endmodule

bind rgb_led_effect_gamma_driver_top rlgd_checker u_rlgd_checker (.*);

// File: dv/tb_rgb_led_effect_gamma_driver_top.sv
// Self-checking bench for the RGB LED effect and gamma driver top level.
// Predicts every duty beat from its own model of the effects, palette and gamma curve.
// Depends on rlgd_pkg and rgb_led_effect_gamma_driver_top.
`timescale 1ns / 100ps

module tb_rgb_led_effect_gamma_driver_top;
   import rlgd_pkg::*;

   localparam int TICK_MS        = 1;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_CMDS     = 76;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } tint_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic       csr_index   = 1'b0;
   logic [2:0] csr_data    = '0;

   // Shadow of the block's registers and effect state
   logic [CODE_W-1:0]  base_eff    = EFF_SOLID;
   logic [CODE_W-1:0]  base_col    = COL_RED;
   logic [FRAME_W-1:0] frame_no    = '0;
   logic               flash_armed = 1'b0;
   logic [CODE_W-1:0]  flash_eff   = '0;
   logic [CODE_W-1:0]  flash_col   = '0;
   logic [NOW_W-1:0]   flash_until = '0;

   req_type pending_cmds[$];
   rsp_type owed_duties[$];
   int      cmds_queued     = 0;
   int      errors          = 0;
   int      sender_idle_pct = 0;
   int      stall_pct       = 0;

   rgb_led_effect_gamma_driver_top #(
      .MS_PER_TICK(TICK_MS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [LEVEL_W-1:0] effect_brightness(input logic [CODE_W-1:0] code,
                                                            input logic [FRAME_W-1:0] frame);
      logic [13:0]       x;
      logic [13:0]       gap;
      logic [CODE_W-1:0] eff;
      eff = CODE_W'(code % 5);
      x   = {frame, 8'h00};
      gap = (x >= 14'd8191) ? (x - 14'd8191) : (14'd8191 - x);
      case (eff)
         EFF_SOLID: return FULL_LEVEL;
         EFF_BLINK: return frame[4] ? FULL_LEVEL : '0;
         EFF_PULSE: return LEVEL_W'(14'd8191 - gap);
         EFF_FLASH: return frame[2] ? FULL_LEVEL : '0;
         default:   return '0;
      endcase
   endfunction

   function automatic tint_type palette(input logic [CODE_W-1:0] idx);
      case (idx)
         COL_GREEN:   return {13'd0,    13'd8191, 13'd0};
         COL_CYAN:    return {13'd0,    13'd8191, 13'd8191};
         COL_RED:     return {13'd8191, 13'd0,    13'd0};
         COL_MAGENTA: return {13'd8191, 13'd0,    13'd8191};
         COL_ORANGE:  return {13'd8191, 13'd5000, 13'd0};
         COL_WHITE:   return {13'd8191, 13'd7200, 13'd6700};
         // index seven folds back onto blue
         default:     return {13'd0,    13'd0,    13'd8191};
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] gamma_duty(input logic [LEVEL_W-1:0] comp,
                                                     input logic [LEVEL_W-1:0] lvl);
      int unsigned s;
      int unsigned sq;
      int unsigned cube;
      s    = (comp * lvl) >> LEVEL_W;
      sq   = (s * s) >> LEVEL_W;
      cube = (sq * s) >> LEVEL_W;
      return LEVEL_W'(FULL_LEVEL - cube);
   endfunction

   task automatic advance_led(input req_type cmd);
      rsp_type           duty;
      logic [CODE_W-1:0] eff;
      logic [CODE_W-1:0] col;
      logic [LEVEL_W-1:0] lvl;
      tint_type          tint;
      if (cmd.operation == OP_FLASH) begin
         frame_no    = '0;
         flash_eff   = cmd.flash_effect_sel;
         flash_col   = cmd.flash_color_sel;
         flash_until = cmd.now_ticks + NOW_W'(cmd.flash_ms / TICK_MS);
         flash_armed = 1'b1;
      end else begin
         if (flash_armed && cmd.now_ticks < flash_until) begin
            eff = flash_eff;
            col = flash_col;
            duty.flash_shown = 1'b1;
         end else begin
            flash_armed = 1'b0;
            eff = base_eff;
            col = base_col;
            duty.flash_shown = 1'b0;
         end
         lvl  = effect_brightness(eff, frame_no);
         tint = palette(col);
         duty.red_duty   = gamma_duty(tint.red, lvl);
         duty.green_duty = gamma_duty(tint.green, lvl);
         duty.blue_duty  = gamma_duty(tint.blue, lvl);
         owed_duties.push_back(duty);
         frame_no = frame_no + 1'b1;
      end
   endtask

   // Command driver: predict on acceptance, then offer the next beat or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) advance_led(req_payload);
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_cmds.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic check_duty(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   // Duty monitor: compare each accepted beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_duties.size() == 0) begin
            $error("duty beat with no prediction waiting");
            errors++;
         end else begin
            want = owed_duties.pop_front();
            check_duty("red_duty", want.red_duty, rsp_payload.red_duty);
            check_duty("green_duty", want.green_duty, rsp_payload.green_duty);
            check_duty("blue_duty", want.blue_duty, rsp_payload.blue_duty);
            check_duty("flash_shown", want.flash_shown, rsp_payload.flash_shown);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_type make_cmd(input logic op, input logic [NOW_W-1:0] now,
                                        input logic [MS_W-1:0] ms, input logic [CODE_W-1:0] eff,
                                        input logic [CODE_W-1:0] col);
      req_type c;
      c.operation        = op;
      c.now_ticks        = now;
      c.flash_ms         = ms;
      c.flash_effect_sel = eff;
      c.flash_color_sel  = col;
      return c;
   endfunction

   function automatic req_type random_cmd();
      return make_cmd(1'($urandom_range(0, 1)), $urandom(), 16'($urandom()),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
   endfunction

   task automatic queue_cmd(input req_type c);
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   // Flash start followed by ticks that walk across its end time
   task automatic queue_flash_train();
      req_type          c;
      logic [NOW_W-1:0] t;
      int               n;
      t = $urandom();
      c = random_cmd();
      c.operation = OP_FLASH;
      c.now_ticks = t;
      if ($urandom_range(0, 3) != 0) c.flash_ms = 16'($urandom_range(0, 40));
      queue_cmd(c);
      n = $urandom_range(1, 12);
      repeat (n) begin
         c = random_cmd();
         c.operation = OP_TICK;
         c.now_ticks = t;
         queue_cmd(c);
         t = t + NOW_W'($urandom_range(0, 6));
      end
   endtask

   // Plain ticks; the odd long run carries the frame counter past its wrap
   task automatic queue_tick_run();
      req_type          c;
      logic [NOW_W-1:0] t;
      int               n;
      t = $urandom();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(2, 10);
      repeat (n) begin
         c = random_cmd();
         c.operation = OP_TICK;
         c.now_ticks = t;
         queue_cmd(c);
         t = t + NOW_W'($urandom_range(0, 4));
      end
   endtask

   task automatic queue_random_mix(input int count);
      int pick;
      cmds_queued = 0;
      while (cmds_queued < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) queue_flash_train();
         else if (pick < 9) queue_tick_run();
         else queue_cmd(random_cmd());
      end
   endtask

   // Hold until every beat is through and the block has settled
   task automatic wait_quiet();
      while (pending_cmds.size() != 0 || req_valid || owed_duties.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [2:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BASE_EFFECT) base_eff = val;
      else base_col = val;
      frame_no = '0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset configuration (solid red)
      queue_cmd(make_cmd(OP_TICK, 32'h0000_0000, 16'h0000, EFF_OFF, COL_BLUE));
      queue_cmd(make_cmd(OP_TICK, 32'hffff_ffff, 16'hffff, EFF_BLINK_ALT, COL_BLUE_ALT));
      queue_cmd(make_cmd(OP_FLASH, 32'd100, 16'd50, EFF_PULSE, COL_WHITE));
      queue_cmd(make_cmd(OP_TICK, 32'd100, 16'd0, EFF_OFF, COL_BLUE));
      queue_cmd(make_cmd(OP_TICK, 32'd120, 16'd0, EFF_OFF, COL_BLUE));
      queue_cmd(make_cmd(OP_TICK, 32'd149, 16'd0, EFF_OFF, COL_BLUE));
      // expiry, then a tick back inside the old window must stay on the base effect
      queue_cmd(make_cmd(OP_TICK, 32'd150, 16'd0, EFF_OFF, COL_BLUE));
      queue_cmd(make_cmd(OP_TICK, 32'd120, 16'd0, EFF_OFF, COL_BLUE));
      // end time wraps past zero, so the flash is already over
      queue_cmd(make_cmd(OP_FLASH, 32'hffff_fff0, 16'hffff, EFF_SOLID, COL_GREEN));
      queue_cmd(make_cmd(OP_TICK, 32'hffff_fff5, 16'd0, EFF_OFF, COL_BLUE));
      // zero-length flash is never shown
      queue_cmd(make_cmd(OP_FLASH, 32'd500, 16'd0, EFF_SOLID, COL_CYAN));
      queue_cmd(make_cmd(OP_TICK, 32'd500, 16'd0, EFF_OFF, COL_BLUE));
      for (int k = 0; k < 8; k++) begin
         queue_cmd(make_cmd(OP_FLASH, 32'd1000, 16'd10, 3'(k), 3'(k)));
         queue_cmd(make_cmd(OP_TICK, 32'd1005, 16'd0, EFF_OFF, COL_BLUE));
      end

      for (int ph = 0; ph < 8; ph++) begin
         wait_quiet();
         case (ph % 4)
            0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
            1:       begin sender_idle_pct = 77; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 77; end
            default: begin sender_idle_pct = 11; stall_pct = 11; end
         endcase
         case (ph)
            0: begin
               write_csr(CSR_BASE_EFFECT, EFF_OFF);
               write_csr(CSR_BASE_COLOR, COL_BLUE);
            end
            1: begin
               write_csr(CSR_BASE_EFFECT, EFF_FLASH);
               write_csr(CSR_BASE_COLOR, COL_WHITE);
            end
            2: begin
               write_csr(CSR_BASE_EFFECT, EFF_BLINK_ALT);
               write_csr(CSR_BASE_COLOR, COL_BLUE_ALT);
            end
            3: begin
               write_csr(CSR_BASE_COLOR, COL_ORANGE);
               write_csr(CSR_BASE_EFFECT, EFF_PULSE);
            end
            default: begin
               write_csr(CSR_BASE_EFFECT, 3'($urandom_range(0, 7)));
               write_csr(CSR_BASE_COLOR, 3'($urandom_range(0, 7)));
            end
         endcase
         queue_random_mix(PHASE_CMDS / 2);
         // pause the sender until every owed duty beat has arrived
         wait_quiet();
         queue_random_mix(PHASE_CMDS - PHASE_CMDS / 2);
      end

      wait_quiet();
      if (errors == 0 && owed_duties.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
